@@ hdl/c2p_pkg.sv @@
// ---------------------------------------------------------------------------
// c2p_pkg: shared types and constants for the cartesian to polar converter
// Holds the per-item control bundle, the arctangent table of the rotation
// cells and the fixed angle codes used by the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

package c2p_pkg;

	// number of rotation cells that resolve the angle
	localparam int CORDIC_STAGES = 20;
	// fraction bits added to the coordinates before rotation
	localparam int ANGLE_SCALE_BITS = 24;
	// coordinate width plus this gives the rotation datapath width
	localparam int CORDIC_EXTRA = 27;
	// accumulated angle, signed, in 1/32768 degree
	localparam int Z_WIDTH = 24;
	// width of the quadrant sum before dropping the guard bits
	localparam int TOT_WIDTH = 24;
	localparam int ANGLE_GUARD = 8;

	// per-item control bundle carried alongside the datapath
	typedef struct packed {
		logic valid;
		logic x_neg;
		logic y_neg;
		logic x_zero;
		logic y_zero;
	} item_ctl_t;

	// atan(2^-i) in 1/32768 degree, rounded
	localparam logic signed [Z_WIDTH-1:0] ATAN_TABLE [0:CORDIC_STAGES-1] = '{
		24'sd1474560, 24'sd870484, 24'sd459940, 24'sd233473, 24'sd117189,
		24'sd58652,   24'sd29333,  24'sd14667,  24'sd7334,   24'sd3667,
		24'sd1833,    24'sd917,    24'sd458,    24'sd229,    24'sd115,
		24'sd57,      24'sd29,     24'sd14,     24'sd7,      24'sd4
	};

	// quarter turn in fine units, the clamp limit of the first-quadrant angle
	localparam logic signed [Z_WIDTH-1:0] FINE_DEG90 = 24'sd2949120;

	// quadrant bases in fine units with the rounding half already folded in
	localparam logic [TOT_WIDTH-1:0] HALF_LSB     = 24'd128;
	localparam logic [TOT_WIDTH-1:0] BASE_DEG180  = 24'd5898368;
	localparam logic [TOT_WIDTH-1:0] BASE_DEG360  = 24'd11796608;

	// output angle codes in 1/128 degree
	localparam logic [15:0] ANGLE_DEG0   = 16'd0;
	localparam logic [15:0] ANGLE_DEG90  = 16'd11520;
	localparam logic [15:0] ANGLE_DEG180 = 16'd23040;
	localparam logic [15:0] ANGLE_DEG270 = 16'd34560;
	localparam logic [15:0] FULL_TURN    = 16'd46080;

	// largest magnitude the output field carries
	localparam logic [15:0] MAG_MAX = 16'hFFFF;

endpackage

`default_nettype wire

@@ hdl/c2p_front.sv @@
// ---------------------------------------------------------------------------
// c2p_front: input conditioning for the cartesian to polar converter
// Takes absolute values and axis flags, squares both coordinates and forms
// the radicand and the scaled starting vector for the cell chain.
// ---------------------------------------------------------------------------
`default_nettype none

module c2p_front #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                                            clk,
	input  wire logic                                            arst_n,
	input  wire logic                                            en,
	input  wire logic                                            valid_in,
	input  wire logic signed [COORD_WIDTH-1:0]                   x_value,
	input  wire logic signed [COORD_WIDTH-1:0]                   y_value,
	output c2p_pkg::item_ctl_t                                   ctl_s3,
	output logic [2*COORD_WIDTH-1:0]                             rad_s3,
	output logic signed [COORD_WIDTH+c2p_pkg::CORDIC_EXTRA-1:0] cx_s3,
	output logic signed [COORD_WIDTH+c2p_pkg::CORDIC_EXTRA-1:0] cy_s3
);
	import c2p_pkg::*;

	localparam int PAD_BITS = CORDIC_EXTRA - ANGLE_SCALE_BITS;

	item_ctl_t ctl_d, ctl_s1, ctl_s2;
	logic [COORD_WIDTH-1:0] x_u, y_u, ax_d, ay_d;
	logic [COORD_WIDTH-1:0] ax_s1, ay_s1, ax_s2, ay_s2;
	logic [2*COORD_WIDTH-1:0] sqx_s2, sqy_s2;

	// absolute values and axis flags
	always_comb begin
		x_u = $unsigned(x_value);
		y_u = $unsigned(y_value);
		ax_d = x_u[COORD_WIDTH-1] ? (~x_u + COORD_WIDTH'(1)) : x_u;
		ay_d = y_u[COORD_WIDTH-1] ? (~y_u + COORD_WIDTH'(1)) : y_u;
		ctl_d.valid  = valid_in;
		ctl_d.x_neg  = x_u[COORD_WIDTH-1];
		ctl_d.y_neg  = y_u[COORD_WIDTH-1];
		ctl_d.x_zero = (x_u == '0);
		ctl_d.y_zero = (y_u == '0);
	end

	// control bundle through the three front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_d;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// abs, squares, then radicand and starting vector
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= ax_d;
			ay_s1  <= ay_d;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			sqx_s2 <= (2*COORD_WIDTH)'(ax_s1) * (2*COORD_WIDTH)'(ax_s1);
			sqy_s2 <= (2*COORD_WIDTH)'(ay_s1) * (2*COORD_WIDTH)'(ay_s1);
			rad_s3 <= sqx_s2 + sqy_s2;
			cx_s3  <= $signed({{PAD_BITS{1'b0}}, ax_s2, {ANGLE_SCALE_BITS{1'b0}}});
			cy_s3  <= $signed({{PAD_BITS{1'b0}}, ay_s2, {ANGLE_SCALE_BITS{1'b0}}});
		end
	end

endmodule

`default_nettype wire

@@ hdl/c2p_cell.sv @@
// ---------------------------------------------------------------------------
// c2p_cell: one cell of the converter chain
// Resolves one bit of the integer square root and performs one vectoring
// rotation; cells past the end of either job pass that part through.
// ---------------------------------------------------------------------------
`default_nettype none

module c2p_cell #(
	parameter int COORD_WIDTH = 16,
	parameter int STAGE       = 0
) (
	input  wire logic                                            clk,
	input  wire logic                                            arst_n,
	input  wire logic                                            en,
	input  wire c2p_pkg::item_ctl_t                              ctl_i,
	input  wire logic [2*COORD_WIDTH-1:0]                        rad_i,
	input  wire logic [COORD_WIDTH+1:0]                          rem_i,
	input  wire logic [COORD_WIDTH-1:0]                          root_i,
	input  wire logic signed [COORD_WIDTH+c2p_pkg::CORDIC_EXTRA-1:0] cx_i,
	input  wire logic signed [COORD_WIDTH+c2p_pkg::CORDIC_EXTRA-1:0] cy_i,
	input  wire logic signed [c2p_pkg::Z_WIDTH-1:0]              z_i,
	output c2p_pkg::item_ctl_t                                   ctl_q,
	output logic [2*COORD_WIDTH-1:0]                             rad_q,
	output logic [COORD_WIDTH+1:0]                               rem_q,
	output logic [COORD_WIDTH-1:0]                               root_q,
	output logic signed [COORD_WIDTH+c2p_pkg::CORDIC_EXTRA-1:0] cx_q,
	output logic signed [COORD_WIDTH+c2p_pkg::CORDIC_EXTRA-1:0] cy_q,
	output logic signed [c2p_pkg::Z_WIDTH-1:0]                  z_q
);
	import c2p_pkg::*;

	localparam int RW = COORD_WIDTH + 2;
	localparam int CW = COORD_WIDTH + CORDIC_EXTRA;

	logic [2*COORD_WIDTH-1:0] rad_d;
	logic [RW-1:0]            rem_d;
	logic [COORD_WIDTH-1:0]   root_d;
	logic signed [CW-1:0]     cx_d, cy_d;
	logic signed [Z_WIDTH-1:0] z_d;

	// one digit of the restoring square root
	if (STAGE < COORD_WIDTH) begin : g_root
		logic [RW-1:0] rem_sh, trial;
		logic          fits;
		always_comb begin
			rem_sh = {rem_i[RW-3:0], rad_i[2*COORD_WIDTH-1 -: 2]};
			trial  = {root_i, 2'b01};
			fits   = (rem_sh >= trial);
			rem_d  = fits ? (rem_sh - trial) : rem_sh;
			root_d = {root_i[COORD_WIDTH-2:0], fits};
			rad_d  = {rad_i[2*COORD_WIDTH-3:0], 2'b00};
		end
	end else begin : g_root_pass
		assign rem_d  = rem_i;
		assign root_d = root_i;
		assign rad_d  = rad_i;
	end

	// one vectoring rotation, driving y toward zero
	if (STAGE < CORDIC_STAGES) begin : g_rot
		logic signed [CW-1:0] dx, dy;
		logic                 up;
		always_comb begin
			dx = cy_i >>> STAGE;
			dy = cx_i >>> STAGE;
			up = !cy_i[CW-1] && (cy_i != '0);
			if (up) begin
				cx_d = cx_i + dx;
				cy_d = cy_i - dy;
				z_d  = z_i + ATAN_TABLE[STAGE];
			end else begin
				cx_d = cx_i - dx;
				cy_d = cy_i + dy;
				z_d  = z_i - ATAN_TABLE[STAGE];
			end
		end
	end else begin : g_rot_pass
		assign cx_d = cx_i;
		assign cy_d = cy_i;
		assign z_d  = z_i;
	end

	// control bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	// cell datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= rad_d;
			rem_q  <= rem_d;
			root_q <= root_d;
			cx_q   <= cx_d;
			cy_q   <= cy_d;
			z_q    <= z_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/c2p_back.sv @@
// ---------------------------------------------------------------------------
// c2p_back: result formatting and output register
// Rounds and saturates the root, clamps the first-quadrant angle, maps it to
// the full circle and holds the result until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module c2p_back #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire c2p_pkg::item_ctl_t                ctl_i,
	input  wire logic [COORD_WIDTH+1:0]            rem_i,
	input  wire logic [COORD_WIDTH-1:0]            root_i,
	input  wire logic signed [c2p_pkg::Z_WIDTH-1:0] z_i,
	input  wire logic                              polar_stall,
	output logic                                   advance,
	output logic                                   polar_valid,
	output logic [15:0]                            magnitude,
	output logic [15:0]                            angle_deg
);
	import c2p_pkg::*;

	localparam int RW = COORD_WIDTH + 2;
	localparam int MW = (COORD_WIDTH + 1 > 16) ? COORD_WIDTH + 1 : 16;

	item_ctl_t ctl_s1;
	logic out_en;
	logic round_up;
	logic [COORD_WIDTH:0] mag_w;
	logic [MW-1:0] mag_ext;
	logic [15:0] mag_d, mag_s1, code_d, code_raw;
	logic [Z_WIDTH-2:0] ang_d, ang_s1;
	logic [TOT_WIDTH-1:0] ang_ext, total;

	// output slot frees when empty or taken; the chain moves if the slot
	// frees or the formatting stage holds nothing
	assign out_en  = !polar_valid || !polar_stall;
	assign advance = out_en || !ctl_s1.valid;

	// round to nearest, saturate, clamp the angle to a quarter turn
	always_comb begin
		round_up = (rem_i > RW'(root_i));
		mag_w    = (COORD_WIDTH+1)'(root_i) + (COORD_WIDTH+1)'(round_up);
		mag_ext  = MW'(mag_w);
		mag_d    = (mag_ext > MW'(MAG_MAX)) ? MAG_MAX : mag_ext[15:0];
		if (z_i[Z_WIDTH-1]) begin
			ang_d = '0;
		end else if (z_i > FINE_DEG90) begin
			ang_d = FINE_DEG90[Z_WIDTH-2:0];
		end else begin
			ang_d = z_i[Z_WIDTH-2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mag_s1 <= mag_d;
			ang_s1 <= ang_d;
		end
	end

	// quadrant mapping, drop guard bits, wrap a full turn to zero
	always_comb begin
		ang_ext = TOT_WIDTH'(ang_s1);
		case ({ctl_s1.x_neg, ctl_s1.y_neg})
			2'b00:   total = ang_ext + HALF_LSB;
			2'b10:   total = BASE_DEG180 - ang_ext;
			2'b11:   total = BASE_DEG180 + ang_ext;
			default: total = BASE_DEG360 - ang_ext;
		endcase
		code_raw = total[ANGLE_GUARD +: 16];
		if (ctl_s1.y_zero) begin
			code_d = ctl_s1.x_neg ? ANGLE_DEG180 : ANGLE_DEG0;
		end else if (ctl_s1.x_zero) begin
			code_d = ctl_s1.y_neg ? ANGLE_DEG270 : ANGLE_DEG90;
		end else if (code_raw >= FULL_TURN) begin
			code_d = ANGLE_DEG0;
		end else begin
			code_d = code_raw;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polar_valid <= 1'b0;
		end else if (out_en) begin
			polar_valid <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			magnitude <= mag_s1;
			angle_deg <= code_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/cartesian_to_polar.sv @@
// ---------------------------------------------------------------------------
// cartesian_to_polar: rectangular to polar converter
// Converts a signed (x, y) pair into its rounded length and its angle in
// 1/128 degree over a full turn.
//
// Usage
//  - coord channel: x_value and y_value, transfer when coord_valid is high
//    and coord_stall is low.
//  - polar channel: magnitude and angle_deg, transfer when polar_valid is
//    high and polar_stall is low. One result per input pair, in order.
//  - pipeline: three front stages (abs, square, sum), one chain cell per root
//    bit or rotation, two formatting stages including the output register.
//  - throughput is one pair per cycle while coord_stall is low; every cell
//    retires a root digit, a rotation or both per clock.
//  - reset clears all valid bits; nothing else needs clearing.
//  - while the receiver stalls, the output register holds its result and
//    the chain keeps moving as long as the formatting stage is empty;
//    once it is full the chain freezes and coord_stall goes high.
// ---------------------------------------------------------------------------
`default_nettype none

module cartesian_to_polar #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          coord_valid,
	output logic                               coord_stall,
	input  wire logic signed [COORD_WIDTH-1:0] x_value,
	input  wire logic signed [COORD_WIDTH-1:0] y_value,
	output logic                               polar_valid,
	input  wire logic                          polar_stall,
	output logic [15:0]                        magnitude,
	output logic [15:0]                        angle_deg
);
	import c2p_pkg::*;

	localparam int DEPTH = (COORD_WIDTH > CORDIC_STAGES) ? COORD_WIDTH : CORDIC_STAGES;
	localparam int RW    = COORD_WIDTH + 2;
	localparam int CW    = COORD_WIDTH + CORDIC_EXTRA;

	logic advance;

	item_ctl_t                 ctl_c  [0:DEPTH];
	logic [2*COORD_WIDTH-1:0]  rad_c  [0:DEPTH];
	logic [RW-1:0]             rem_c  [0:DEPTH];
	logic [COORD_WIDTH-1:0]    root_c [0:DEPTH];
	logic signed [CW-1:0]      cx_c   [0:DEPTH];
	logic signed [CW-1:0]      cy_c   [0:DEPTH];
	logic signed [Z_WIDTH-1:0] z_c    [0:DEPTH];

	assign coord_stall = !advance;

	// front end: abs, squares, radicand, starting vector
	c2p_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.valid_in (coord_valid),
		.x_value  (x_value),
		.y_value  (y_value),
		.ctl_s3   (ctl_c[0]),
		.rad_s3   (rad_c[0]),
		.cx_s3    (cx_c[0]),
		.cy_s3    (cy_c[0])
	);

	// root and angle accumulators start from zero
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;
	assign z_c[0]    = '0;

	// chain of cells
	for (genvar k = 0; k < DEPTH; k++) begin : g_chain
		c2p_cell #(
			.COORD_WIDTH(COORD_WIDTH),
			.STAGE      (k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (advance),
			.ctl_i  (ctl_c[k]),
			.rad_i  (rad_c[k]),
			.rem_i  (rem_c[k]),
			.root_i (root_c[k]),
			.cx_i   (cx_c[k]),
			.cy_i   (cy_c[k]),
			.z_i    (z_c[k]),
			.ctl_q  (ctl_c[k+1]),
			.rad_q  (rad_c[k+1]),
			.rem_q  (rem_c[k+1]),
			.root_q (root_c[k+1]),
			.cx_q   (cx_c[k+1]),
			.cy_q   (cy_c[k+1]),
			.z_q    (z_c[k+1])
		);
	end

	// formatting and output register
	c2p_back #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_i       (ctl_c[DEPTH]),
		.rem_i       (rem_c[DEPTH]),
		.root_i      (root_c[DEPTH]),
		.z_i         (z_c[DEPTH]),
		.polar_stall (polar_stall),
		.advance     (advance),
		.polar_valid (polar_valid),
		.magnitude   (magnitude),
		.angle_deg   (angle_deg)
	);

endmodule

`default_nettype wire

@@ hdl/c2p_checker.sv @@
// ---------------------------------------------------------------------------
// c2p_checker: port-level checks for the cartesian to polar converter
// Watches the top-level ports and flags results or stalls that cannot occur
// in a working converter.
// ---------------------------------------------------------------------------
`default_nettype none

module c2p_checker #(
	parameter int COORD_WIDTH = 16
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          coord_valid,
	input wire logic                          coord_stall,
	input wire logic signed [COORD_WIDTH-1:0] x_value,
	input wire logic signed [COORD_WIDTH-1:0] y_value,
	input wire logic                          polar_valid,
	input wire logic                          polar_stall,
	input wire logic [15:0]                   magnitude,
	input wire logic [15:0]                   angle_deg
);
	import c2p_pkg::*;

	// a stalled result stays put until its transfer
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		polar_valid && polar_stall |=> polar_valid && $stable(magnitude)
			&& $stable(angle_deg))
		else $error("result changed while stalled");

	// angle stays below a full turn
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		polar_valid |-> (angle_deg < FULL_TURN))
		else $error("angle at or beyond full turn");

	// input is held back only behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		coord_stall |-> polar_valid && polar_stall)
		else $error("input stalled with free output");

	// zero length only comes from the origin, whose angle is zero
	a_origin_angle: assert property (@(posedge clk) disable iff (!arst_n)
		polar_valid && (magnitude == 16'd0) |-> (angle_deg == ANGLE_DEG0))
		else $error("zero magnitude with nonzero angle");

	// coordinates of an input transfer are fully known
	a_coord_known: assert property (@(posedge clk) disable iff (!arst_n)
		coord_valid && !coord_stall |-> !$isunknown({x_value, y_value}))
		else $error("input transfer with unknown coordinates");

endmodule

bind cartesian_to_polar c2p_checker #(.COORD_WIDTH(COORD_WIDTH)) u_c2p_checker (.*);

`default_nettype wire
